[rtl/iefilt_pkg.sv]
package iefilt_pkg;

	typedef logic [2:0] verdict_t;

	localparam verdict_t VERDICT_MATCH      = 3'd0;
	localparam verdict_t VERDICT_TOO_SHORT  = 3'd1;
	localparam verdict_t VERDICT_NOT_IPV4   = 3'd2;
	localparam verdict_t VERDICT_NOT_ICMP   = 3'd3;
	localparam verdict_t VERDICT_BAD_IHL    = 3'd4;
	localparam verdict_t VERDICT_NOT_EXPECT = 3'd5;
	localparam verdict_t VERDICT_BAD_CSUM   = 3'd6;

	localparam int MAX_FRAME_BYTES_DEF = 2048;
	localparam int ICMP_HEADER_BYTES   = 8;
	localparam int ETH_HDR_BYTES       = 14;
	localparam int MIN_FRAME_LEN       = 42;
	localparam int MAC_FIRST_POS       = 6;
	localparam int MAC_BYTES           = 6;
	localparam int ETYPE_HI_POS        = 12;
	localparam int ETYPE_LO_POS        = 13;
	localparam int IHL_POS             = 14;
	localparam int PROTO_POS           = 23;
	localparam int IHL_MIN             = 5;

	localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
	localparam logic [7:0]  PROTO_ICMP   = 8'd1;
	localparam logic [7:0]  ECHO_REPLY   = 8'd0;
	localparam logic [7:0]  ECHO_CODE    = 8'd0;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_IDENT    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_SEQUENCE = 1'd1;

	localparam logic [15:0] IDENT_RESET    = 16'd0;
	localparam logic [15:0] SEQUENCE_RESET = 16'd1;

endpackage

[rtl/icmp_echo_reply_frame_filter_core.sv]
// icmp echo reply filter for a received ethernet frame
//
// frame channel: one frame byte per request (frame_byte, frame_end marks the
// last byte), taken when frame_valid is high and frame_stall is low. a new
// byte can be taken every cycle that frame_stall is low, so a frame streams at one byte per cycle.
// result channel: one request per frame (verdict, source_mac), offered on
// result_valid and held while result_stall is high.
// after the last byte is taken, the snapshot stage captures the frame fields
// and the output stage registers the verdict judged from them.
// frame_stall only rises when a finished result is held by result_stall and
// a second finished frame waits behind it; otherwise bytes keep flowing.
// the cfg port writes the expected identifier and sequence number; write it
// while no frame is in flight.
// reset clears the byte counter, the captured fields and the valid flags of
// both pipeline stages, and loads identifier 0 and sequence 1.
// bytes beyond MAX_FRAME_BYTES are ignored; the frame is judged on the rest.
module icmp_echo_reply_frame_filter_core #(
	parameter int MAX_FRAME_BYTES = iefilt_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  frame_valid,
	output logic                                  frame_stall,
	input  logic [7:0]                            frame_byte,
	input  logic                                  frame_end,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output iefilt_pkg::verdict_t                  verdict,
	output logic [47:0]                           source_mac,
	input  logic                                  cfg_we,
	input  logic [iefilt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [iefilt_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import iefilt_pkg::*;

	localparam int PosW = $clog2(MAX_FRAME_BYTES + 1);
	localparam logic [PosW-1:0] PosMax = PosW'(MAX_FRAME_BYTES);

	// per-frame capture state
	logic [PosW-1:0] pos_q;
	logic [47:0]     mac_q;
	logic [15:0]     etype_q;
	logic [3:0]      ihl_q;
	logic [7:0]      proto_q;
	logic [7:0]      hdr_q [ICMP_HEADER_BYTES];

	logic [15:0] ident_q;
	logic [15:0] seq_q;

	// snapshot of a finished frame
	logic            valid_s1;
	logic [PosW-1:0] pos_s1;
	logic [47:0]     mac_s1;
	logic [15:0]     etype_s1;
	logic [3:0]      ihl_s1;
	logic [7:0]      proto_s1;
	logic [7:0]      hdr_s1 [ICMP_HEADER_BYTES];

	logic            out_valid_q;
	verdict_t        verdict_q;
	logic [47:0]     mac_out_q;

	logic            accept;
	logic            adv_s1;
	logic            capture;
	logic [3:0]      ihl_cur;
	logic [PosW-1:0] start;
	logic [PosW-1:0] off;
	logic            in_hdr;
	logic [PosW-1:0] pos_n;
	logic [47:0]     mac_n;
	logic [15:0]     etype_n;
	logic [3:0]      ihl_n;
	logic [7:0]      proto_n;
	logic [7:0]      hdr_n [ICMP_HEADER_BYTES];

	assign adv_s1      = !out_valid_q || !result_stall;
	assign frame_stall = valid_s1 && !adv_s1;
	assign accept      = frame_valid && !frame_stall;

	always_comb begin
		capture = pos_q < PosMax;
		// the ihl byte itself already moves the icmp window
		ihl_cur = (pos_q == PosW'(IHL_POS)) ? frame_byte[3:0] : ihl_q;
		start   = PosW'(ETH_HDR_BYTES) + PosW'({ihl_cur, 2'b00});
		off     = pos_q - start;
		in_hdr  = capture && (pos_q >= start) && (off < PosW'(ICMP_HEADER_BYTES));

		pos_n   = capture ? pos_q + PosW'(1) : pos_q;
		mac_n   = mac_q;
		etype_n = etype_q;
		ihl_n   = ihl_q;
		proto_n = proto_q;
		for (int i = 0; i < ICMP_HEADER_BYTES; i++) begin
			hdr_n[i] = hdr_q[i];
		end
		if (capture) begin
			for (int i = 0; i < MAC_BYTES; i++) begin
				if (pos_q == PosW'(MAC_FIRST_POS + i)) begin
					mac_n[8*(MAC_BYTES-1-i) +: 8] = frame_byte;
				end
			end
			if (pos_q == PosW'(ETYPE_HI_POS) || pos_q == PosW'(ETYPE_LO_POS)) begin
				etype_n = {etype_q[7:0], frame_byte};
			end
			if (pos_q == PosW'(IHL_POS)) begin
				ihl_n = frame_byte[3:0];
			end
			if (pos_q == PosW'(PROTO_POS)) begin
				proto_n = frame_byte;
			end
			if (in_hdr) begin
				hdr_n[off[$clog2(ICMP_HEADER_BYTES)-1:0]] = frame_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			mac_q   <= '0;
			etype_q <= '0;
			ihl_q   <= '0;
			proto_q <= '0;
			for (int i = 0; i < ICMP_HEADER_BYTES; i++) begin
				hdr_q[i] <= '0;
			end
		end else if (accept) begin
			if (frame_end) begin
				pos_q   <= '0;
				mac_q   <= '0;
				etype_q <= '0;
				ihl_q   <= '0;
				proto_q <= '0;
				for (int i = 0; i < ICMP_HEADER_BYTES; i++) begin
					hdr_q[i] <= '0;
				end
			end else begin
				pos_q   <= pos_n;
				mac_q   <= mac_n;
				etype_q <= etype_n;
				ihl_q   <= ihl_n;
				proto_q <= proto_n;
				for (int i = 0; i < ICMP_HEADER_BYTES; i++) begin
					hdr_q[i] <= hdr_n[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ident_q <= IDENT_RESET;
			seq_q   <= SEQUENCE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_EXPECTED_IDENT:    ident_q <= cfg_data;
				CFG_EXPECTED_SEQUENCE: seq_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && frame_end) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && frame_end) begin
			pos_s1   <= pos_n;
			mac_s1   <= mac_n;
			etype_s1 <= etype_n;
			ihl_s1   <= ihl_n;
			proto_s1 <= proto_n;
			for (int i = 0; i < ICMP_HEADER_BYTES; i++) begin
				hdr_s1[i] <= hdr_n[i];
			end
		end
	end

	// judge the snapshot
	logic [PosW-1:0] icmp_end_s1;
	logic [15:0]     w0, w2, w4, w6;
	logic [17:0]     sum;
	logic [16:0]     fold1;
	logic [15:0]     fold2;
	logic [15:0]     calc;
	verdict_t        verdict_n;

	always_comb begin
		icmp_end_s1 = PosW'(ETH_HDR_BYTES + ICMP_HEADER_BYTES) + PosW'({ihl_s1, 2'b00});
		w0    = {hdr_s1[0], hdr_s1[1]};
		w2    = {hdr_s1[2], hdr_s1[3]};
		w4    = {hdr_s1[4], hdr_s1[5]};
		w6    = {hdr_s1[6], hdr_s1[7]};
		sum   = 18'(w0) + 18'(w4) + 18'(w6);
		fold1 = 17'(sum[17:16]) + 17'(sum[15:0]);
		fold2 = fold1[15:0] + 16'(fold1[16]);
		calc  = ~fold2;

		if (pos_s1 < PosW'(MIN_FRAME_LEN)) begin
			verdict_n = VERDICT_TOO_SHORT;
		end else if (etype_s1 != ETYPE_IPV4) begin
			verdict_n = VERDICT_NOT_IPV4;
		end else if (proto_s1 != PROTO_ICMP) begin
			verdict_n = VERDICT_NOT_ICMP;
		end else if (ihl_s1 < 4'(IHL_MIN)) begin
			verdict_n = VERDICT_BAD_IHL;
		end else if (pos_s1 < icmp_end_s1) begin
			verdict_n = VERDICT_TOO_SHORT;
		end else if (hdr_s1[0] != ECHO_REPLY || hdr_s1[1] != ECHO_CODE ||
				w4 != ident_q || w6 != seq_q) begin
			verdict_n = VERDICT_NOT_EXPECT;
		end else if (calc != w2) begin
			verdict_n = VERDICT_BAD_CSUM;
		end else begin
			verdict_n = VERDICT_MATCH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			verdict_q <= verdict_n;
			mac_out_q <= mac_s1;
		end
	end

	assign result_valid = out_valid_q;
	assign verdict      = verdict_q;
	assign source_mac   = mac_out_q;

endmodule

[rtl/iefilt_checker.sv]
module iefilt_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 frame_valid,
	input logic                 frame_stall,
	input logic                 frame_end,
	input logic                 result_valid,
	input logic                 result_stall,
	input iefilt_pkg::verdict_t verdict,
	input logic [47:0]          source_mac
);
	import iefilt_pkg::*;

	// a held result keeps its contents
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			result_valid && $stable(verdict) && $stable(source_mac))
		else $error("result changed while stalled");

	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> verdict <= VERDICT_BAD_CSUM)
		else $error("verdict code out of range");

	// a fresh result traces back to a taken last byte through the snapshot and output stages
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(frame_valid && !frame_stall && frame_end, 2))
		else $error("result without a finished frame");

	// the frame side only waits behind a pending result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		frame_stall |-> result_valid && result_stall)
		else $error("frame stalled with no pending result");

endmodule

bind icmp_echo_reply_frame_filter_core iefilt_checker u_iefilt_checker (.*);
